### rtl/core/cat_pkg.sv
`default_nettype none

package cat_pkg;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_BETWEEN  = 3'd0,
      MODE_WORD     = 3'd1,
      MODE_QUOTE    = 3'd2,
      MODE_SLASH    = 3'd3,
      MODE_LINECMT  = 3'd4,
      MODE_BLOCKCMT = 3'd5
   } mode_type;

   // Token kinds
   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_QUOTE = 2'd1;
   localparam logic [1:0] KIND_PUNCT = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_STRIP_C     = 2'd0;
   localparam logic [1:0] CSR_STRIP_SHELL = 2'd1;
   localparam logic [1:0] CSR_KEEP_QUOTES = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam logic [15:0] SPACE_MAX = 16'hFFFF;

   // Default queue depth between front and back
   localparam int CAT_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic strip_c;
      logic strip_shell;
      logic keep_quotes;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic [7:0]  tok_byte;
      logic [1:0]  tok_kind;
      logic        tok_first;
      logic        tok_last;
      logic        tok_empty;
      logic [15:0] space_before;
      logic        text_done;
      logic        open_comment_error;
   } tok_type;

   // Up to two words pushed per accepted item
   typedef struct packed {
      logic [1:0]        count;
      tok_type [1:0]     word;
   } push_type;

endpackage

`default_nettype wire

### rtl/core/cat_front.sv
`default_nettype none

module cat_front
   import cat_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_text,
   input  wire logic       queue_room,
   output push_type        push
);

   // Scanner state
   mode_type    mode_ff, mode_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        held_first_ff, held_first_in;
   logic [1:0]  held_kind_ff, held_kind_in;
   logic [7:0]  quote_char_ff, quote_char_in;
   logic [15:0] prev_ff, prev_in;
   logic [1:0]  qlen_ff, qlen_in;
   logic [15:0] space_ff, space_in;

   logic          accept;
   logic [1:0]    n_res;
   tok_type [1:0] res;
   logic          restart;
   logic          had;
   logic          err;
   logic [7:0]    b;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == SPACE_MAX) ? v : v + 16'd1;
   endfunction

   // Append one result word; a first byte takes the space count
   function automatic void put_tok(inout tok_type [1:0] r, inout logic [1:0] n,
                                   inout logic [15:0] sc, input logic [7:0] c,
                                   input logic [1:0] k, input logic first,
                                   input logic last, input logic empty,
                                   input logic done, input logic oerr);
      tok_type t;
      t.tok_byte           = c;
      t.tok_kind           = k;
      t.tok_first          = first;
      t.tok_last           = last;
      t.tok_empty          = empty;
      t.space_before       = (first && !done) ? sc : 16'd0;
      t.text_done          = done;
      t.open_comment_error = oerr;
      if (first && !done) sc = 16'd0;
      if (n == 2'd0) r[0] = t;
      else if (n == 2'd1) r[1] = t;
      if (n != 2'd2) n = n + 2'd1;
   endfunction

   assign accept = req_valid && req_ready;
   assign b      = req_in_byte;

   // Next state and result words for one byte
   always_comb begin
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      held_kind_in  = held_kind_ff;
      quote_char_in = quote_char_ff;
      prev_in       = prev_ff;
      qlen_in       = qlen_ff;
      space_in      = space_ff;
      n_res         = 2'd0;
      res           = '0;
      restart       = 1'b0;
      had           = 1'b0;
      err           = 1'b0;
      if (accept && req_end_of_text) begin
         // flush pending token, then report end of text
         case (mode_ff)
            MODE_WORD: begin
               if (held_valid_in)
                  put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                          held_first_in, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            MODE_QUOTE: begin
               if (held_valid_in)
                  put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                          held_first_in, 1'b1, 1'b0, 1'b0, 1'b0);
               else
                  put_tok(res, n_res, space_in, 8'd0, KIND_QUOTE,
                          1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            end
            MODE_SLASH: begin
               put_tok(res, n_res, space_in, CH_SLASH, KIND_PUNCT,
                       1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            MODE_BLOCKCMT: begin
               err = 1'b1;
            end
            default: begin
            end
         endcase
         put_tok(res, n_res, space_in, 8'd0, KIND_WORD,
                 1'b0, 1'b0, 1'b0, 1'b1, err);
         mode_in       = MODE_BETWEEN;
         held_byte_in  = 8'd0;
         held_valid_in = 1'b0;
         held_first_in = 1'b0;
         held_kind_in  = KIND_WORD;
         quote_char_in = 8'd0;
         prev_in       = 16'd0;
         qlen_in       = 2'd0;
         space_in      = 16'd0;
      end else if (accept) begin
         case (mode_ff)
            MODE_WORD: begin
               if (held_valid_in)
                  put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                          held_first_in, !is_word(b), 1'b0, 1'b0, 1'b0);
               if (is_word(b)) begin
                  held_byte_in  = b;
                  held_kind_in  = KIND_WORD;
                  held_first_in = 1'b0;
                  held_valid_in = 1'b1;
               end else begin
                  held_valid_in = 1'b0;
                  restart       = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (b == CH_NL) begin
                  // unclosed string ends before the newline
                  if (held_valid_in)
                     put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                             held_first_in, 1'b1, 1'b0, 1'b0, 1'b0);
                  else
                     put_tok(res, n_res, space_in, 8'd0, KIND_QUOTE,
                             1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
                  held_valid_in = 1'b0;
                  mode_in       = MODE_BETWEEN;
                  space_in      = sat_inc(space_in);
               end else if (b == quote_char_ff &&
                            (qlen_ff == 2'd0 || prev_ff[7:0] != CH_BSLASH ||
                             (qlen_ff == 2'd2 && prev_ff[15:8] == CH_BSLASH))) begin
                  // closing quote
                  if (cfg.keep_quotes) begin
                     had = held_valid_in;
                     if (held_valid_in)
                        put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                                held_first_in, 1'b0, 1'b0, 1'b0, 1'b0);
                     put_tok(res, n_res, space_in, b, KIND_QUOTE,
                             !had, 1'b1, 1'b0, 1'b0, 1'b0);
                  end else if (held_valid_in) begin
                     put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                             held_first_in, 1'b1, 1'b0, 1'b0, 1'b0);
                  end else begin
                     put_tok(res, n_res, space_in, 8'd0, KIND_QUOTE,
                             1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
                  end
                  held_valid_in = 1'b0;
                  mode_in       = MODE_BETWEEN;
               end else begin
                  // content byte: release the held one, hold this one
                  had = held_valid_in;
                  if (held_valid_in)
                     put_tok(res, n_res, space_in, held_byte_in, held_kind_in,
                             held_first_in, 1'b0, 1'b0, 1'b0, 1'b0);
                  held_byte_in  = b;
                  held_kind_in  = KIND_QUOTE;
                  held_first_in = !had;
                  held_valid_in = 1'b1;
                  prev_in       = {prev_ff[7:0], b};
                  if (qlen_ff != 2'd2) qlen_in = qlen_ff + 2'd1;
               end
            end
            MODE_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = MODE_LINECMT;
               end else if (b == CH_STAR) begin
                  mode_in = MODE_BLOCKCMT;
                  prev_in = 16'd0;
               end else begin
                  put_tok(res, n_res, space_in, CH_SLASH, KIND_PUNCT,
                          1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
                  restart = 1'b1;
               end
            end
            MODE_LINECMT: begin
               if (b == CH_NL) begin
                  mode_in  = MODE_BETWEEN;
                  space_in = sat_inc(space_in);
               end
            end
            MODE_BLOCKCMT: begin
               if (prev_ff[7:0] == CH_STAR && b == CH_SLASH) begin
                  mode_in = MODE_BETWEEN;
                  prev_in = 16'd0;
               end else begin
                  prev_in = (b == CH_NL) ? 16'd0 : {8'd0, b};
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase

         // classify a byte where a token may start
         if (restart) begin
            mode_in = MODE_BETWEEN;
            if (is_space(b)) begin
               space_in = sat_inc(space_in);
            end else if (cfg.strip_c && b == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (cfg.strip_shell && b == CH_HASH) begin
               mode_in = MODE_LINECMT;
            end else if (is_word(b)) begin
               held_byte_in  = b;
               held_kind_in  = KIND_WORD;
               held_first_in = 1'b1;
               held_valid_in = 1'b1;
               mode_in       = MODE_WORD;
            end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
               quote_char_in = b;
               qlen_in       = 2'd0;
               prev_in       = 16'd0;
               held_valid_in = 1'b0;
               if (cfg.keep_quotes) begin
                  held_byte_in  = b;
                  held_kind_in  = KIND_QUOTE;
                  held_first_in = 1'b1;
                  held_valid_in = 1'b1;
               end
               mode_in = MODE_QUOTE;
            end else begin
               put_tok(res, n_res, space_in, b, KIND_PUNCT,
                       1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
            end
         end
      end
   end

   // Handshake and queue push
   always_comb begin
      req_ready  = queue_room;
      push.count = n_res;
      push.word  = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BETWEEN;
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_kind_ff  <= KIND_WORD;
         quote_char_ff <= 8'd0;
         prev_ff       <= 16'd0;
         qlen_ff       <= 2'd0;
         space_ff      <= 16'd0;
      end else begin
         mode_ff       <= mode_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         held_kind_ff  <= held_kind_in;
         quote_char_ff <= quote_char_in;
         prev_ff       <= prev_in;
         qlen_ff       <= qlen_in;
         space_ff      <= space_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cat_queue.sv
`default_nettype none

module cat_queue
   import cat_pkg::*;
#(
   parameter int DEPTH = CAT_QUEUE_DEPTH,
   localparam int PW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire push_type    push,
   output logic             room,
   output logic [CW-1:0]    count,
   output logic             pop_valid,
   output tok_type          pop_word,
   input  wire logic        pop_ready
);

   tok_type        mem_ff [DEPTH];
   tok_type        head_ff;
   logic [PW-1:0]  wptr_ff, wptr_in;
   logic [PW-1:0]  rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [PW-1:0]  wptr_next;
   logic           pop;

   function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign wptr_next = step(wptr_ff);
   assign pop       = pop_ready && (count_ff != '0);
   assign pop_valid = count_ff != '0;
   // word taken by the most recent pop
   assign pop_word  = head_ff;
   assign count     = count_ff;
   // room for the two words one item may cause
   assign room      = count_ff <= CW'(DEPTH - 2);

   // Pointer and fill updates
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      if (push.count == 2'd1) wptr_in = wptr_next;
      else if (push.count == 2'd2) wptr_in = step(wptr_next);
      if (pop) rptr_in = step(rptr_ff);
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   // Storage writes; the head word is read out on each pop
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wptr_ff] <= push.word[0];
      if (push.count == 2'd2) mem_ff[wptr_next] <= push.word[1];
      if (pop) head_ff <= mem_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cat_back.sv
`default_nettype none

module cat_back
   import cat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   input  wire tok_type     pop_word,
   output logic             pop_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_tok_byte,
   output logic [1:0]       rsp_tok_kind,
   output logic             rsp_tok_first,
   output logic             rsp_tok_last,
   output logic             rsp_tok_empty,
   output logic [15:0]      rsp_space_before,
   output logic             rsp_text_done,
   output logic             rsp_open_comment_error
);

   logic    valid_ff, valid_in;
   logic    load;

   // Output stage refills when empty or being taken; the popped word is
   // held by the queue's registered read until the next pop
   assign pop_ready = !valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_tok_byte           = pop_word.tok_byte;
   assign rsp_tok_kind           = pop_word.tok_kind;
   assign rsp_tok_first          = pop_word.tok_first;
   assign rsp_tok_last           = pop_word.tok_last;
   assign rsp_tok_empty          = pop_word.tok_empty;
   assign rsp_space_before       = pop_word.space_before;
   assign rsp_text_done          = pop_word.text_done;
   assign rsp_open_comment_error = pop_word.open_comment_error;

endmodule

`default_nettype wire

### rtl/core/comment_aware_tokenizer.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_in_byte, req_end_of_text
// rsp       out        rsp_valid/rsp_ready    token byte, kind, marks, space count, done
// csr       in         csr_write              csr_index, csr_data
//
// One text byte is taken each cycle while the queue has room for two words.
// A byte causes up to two words; words leave the queue one per cycle while rsp_ready
// is high, so the sustained rate is one byte a cycle while bytes average one word or less.
// req_ready drops when the queue has fewer than two free slots.
// Synchronous reset clears scanner, queue and output register; no clearing pass.
// Words of an accepted byte pass through queue storage and the registered head word to the outputs.

module comment_aware_tokenizer
   import cat_pkg::*;
#(
   parameter int QUEUE_DEPTH = CAT_QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [0:0]  csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_tok_byte,
   output logic [1:0]       rsp_tok_kind,
   output logic             rsp_tok_first,
   output logic             rsp_tok_last,
   output logic             rsp_tok_empty,
   output logic [15:0]      rsp_space_before,
   output logic             rsp_text_done,
   output logic             rsp_open_comment_error
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type        cfg_ff, cfg_in;
   push_type       push;
   logic           room;
   logic [CW-1:0]  q_count;
   logic           pop_valid;
   logic           pop_ready;
   tok_type        pop_word;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_STRIP_C:     cfg_in.strip_c     = csr_data[0];
            CSR_STRIP_SHELL: cfg_in.strip_shell = csr_data[0];
            CSR_KEEP_QUOTES: cfg_in.keep_quotes = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   cat_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .queue_room      (room),
      .push            (push)
   );

   cat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .count     (q_count),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready)
   );

   cat_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .pop_valid              (pop_valid),
      .pop_word               (pop_word),
      .pop_ready              (pop_ready),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_tok_byte           (rsp_tok_byte),
      .rsp_tok_kind           (rsp_tok_kind),
      .rsp_tok_first          (rsp_tok_first),
      .rsp_tok_last           (rsp_tok_last),
      .rsp_tok_empty          (rsp_tok_empty),
      .rsp_space_before       (rsp_space_before),
      .rsp_text_done          (rsp_text_done),
      .rsp_open_comment_error (rsp_open_comment_error)
   );

   // Queue never holds more words than it has slots
   assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH))
      else $error("queue overflow");

   // Words are pushed only for an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (req_valid && req_ready))
      else $error("push without accepted byte");

   // End of text always produces its report word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_text) |-> (push.count != 2'd0))
      else $error("end of text without report");

   // Output register is empty right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire
